### hw/rtl/ili_pkg.sv
// Shared constants, status and operation codes, and the cell control type for the indexed list.
package ili_pkg;

    localparam int CAPACITY = 64;
    localparam int DATA_W   = 32;
    localparam int OP_W     = 3;
    localparam int POS_W    = 7;
    localparam int COUNT_W  = 7;
    localparam int STAT_W   = 2;
    localparam int LEN_W    = $clog2(CAPACITY + 1);
    localparam int CMP_W    = (LEN_W > POS_W) ? LEN_W : POS_W;
    localparam int GRP      = 8;
    localparam int NGRP     = (CAPACITY + GRP - 1) / GRP;

    localparam logic [OP_W-1:0] OP_READ     = 3'd0;
    localparam logic [OP_W-1:0] OP_INS_HEAD = 3'd1;
    localparam logic [OP_W-1:0] OP_INS_TAIL = 3'd2;
    localparam logic [OP_W-1:0] OP_INS_POS  = 3'd3;
    localparam logic [OP_W-1:0] OP_DELETE   = 3'd4;

    localparam logic [STAT_W-1:0] ST_DONE   = 2'd0;
    localparam logic [STAT_W-1:0] ST_BADPOS = 2'd1;
    localparam logic [STAT_W-1:0] ST_FULL   = 2'd2;

    localparam logic [CMP_W-1:0] CAP_CMP = CMP_W'(CAPACITY);

    typedef struct packed {
        logic              up;     // insert: open a slot at position at
        logic              down;   // delete: close the slot at position at
        logic [CMP_W-1:0]  at;     // target position, also the read position
        logic [DATA_W-1:0] value;  // value written by an insert
    } t_cell_ctl;

endpackage

### hw/rtl/ili_cell.sv
// One storage cell of the list: holds one entry and trades it with its neighbors.
module ili_cell (
    input  logic                       i_clk,
    input  ili_pkg::t_cell_ctl         i_ctl,
    input  logic [ili_pkg::CMP_W-1:0]  i_index,
    input  logic [ili_pkg::DATA_W-1:0] i_left,
    input  logic [ili_pkg::DATA_W-1:0] i_right,
    output logic [ili_pkg::DATA_W-1:0] o_value,
    output logic [ili_pkg::DATA_W-1:0] o_read
);
    import ili_pkg::*;

    logic [DATA_W-1:0] r_val;

    // An insert moves every entry at or above the target up by one; a delete
    // pulls every entry at or above the target down from its upper neighbor.
    always_ff @(posedge i_clk) begin
        if (i_ctl.up) begin
            if (i_index > i_ctl.at) begin
                r_val <= i_left;
            end else if (i_index == i_ctl.at) begin
                r_val <= i_ctl.value;
            end
        end else if (i_ctl.down && (i_index >= i_ctl.at)) begin
            r_val <= i_right;
        end
    end

    assign o_value = r_val;
    assign o_read  = (i_index == i_ctl.at) ? r_val : '0;

endmodule

### hw/rtl/indexed_list_insert_delete.sv
// Top level of the indexed list: request decode, the row of cells and the result register.
//
//  Channel  | Direction | Handshake                  | Payload
//  ---------+-----------+----------------------------+-----------------------------------------
//  request  | in        | i_in_valid / o_in_ready    | i_operation, i_position, i_item_value
//  result   | out       | o_out_valid / i_out_ready  | o_read_value, o_status, o_count_after
//
// A request beat is accepted in the idle state; in the execute state every cell shifts,
// holds or loads at once and the first level of the OR tree that gathers the addressed
// cell for a read is registered; the done state finishes that tree and loads the result
// register. A new beat is taken only in the idle state, once the last one is through.
// Reset (i_rst_n low at a clock edge) empties the list and drops any pending result;
// cell contents are left as they are. A result that is not taken stalls the block in
// its final cycle only while the result register is still full.
module indexed_list_insert_delete (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_in_valid,
    output logic                        o_in_ready,
    input  logic [ili_pkg::OP_W-1:0]    i_operation,
    input  logic [ili_pkg::POS_W-1:0]   i_position,
    input  logic signed [ili_pkg::DATA_W-1:0] i_item_value,
    output logic                        o_out_valid,
    input  logic                        i_out_ready,
    output logic signed [ili_pkg::DATA_W-1:0] o_read_value,
    output logic [ili_pkg::STAT_W-1:0]  o_status,
    output logic [ili_pkg::COUNT_W-1:0] o_count_after
);
    import ili_pkg::*;

    localparam logic [1:0] S_IDLE = 2'd0;
    localparam logic [1:0] S_EXEC = 2'd1;
    localparam logic [1:0] S_DONE = 2'd2;

    logic [1:0]         r_state;
    logic [1:0]         n_state;
    logic [LEN_W-1:0]   r_len;
    t_cell_ctl          r_ctl;
    t_cell_ctl          n_ctl;
    t_cell_ctl          w_cell_ctl;
    logic [STAT_W-1:0]  r_stat;
    logic [STAT_W-1:0]  n_stat;
    logic               r_is_read;
    logic               n_is_read;
    logic [DATA_W-1:0]  r_grp [NGRP];
    logic [DATA_W-1:0]  n_grp [NGRP];
    logic [DATA_W-1:0]  w_val [CAPACITY];
    logic [DATA_W-1:0]  w_rd  [CAPACITY];
    logic [DATA_W-1:0]  w_gather;
    logic               r_out_valid;
    logic [DATA_W-1:0]  r_out_rd;
    logic [STAT_W-1:0]  r_out_stat;
    logic [COUNT_W-1:0] r_out_cnt;
    logic               w_accept;
    logic               w_load_out;
    logic [CMP_W-1:0]   w_len_cmp;
    logic [CMP_W-1:0]   w_pos_cmp;

    assign o_in_ready = (r_state == S_IDLE);
    assign w_accept   = i_in_valid && o_in_ready;
    assign w_load_out = (r_state == S_DONE) && (!r_out_valid || i_out_ready);
    assign w_len_cmp  = CMP_W'(r_len);
    assign w_pos_cmp  = CMP_W'(i_position);

    // Decode the request against the current length. The position check of an
    // insert comes before the full check.
    always_comb begin
        n_ctl       = '0;
        n_ctl.value = i_item_value;
        n_ctl.at    = w_pos_cmp;
        n_stat      = ST_BADPOS;
        n_is_read   = 1'b0;
        unique case (i_operation)
            OP_READ: begin
                n_is_read = 1'b1;
                if (w_pos_cmp < w_len_cmp) begin
                    n_stat = ST_DONE;
                end
            end
            OP_INS_HEAD, OP_INS_TAIL, OP_INS_POS: begin
                if (i_operation == OP_INS_HEAD) begin
                    n_ctl.at = '0;
                end else if (i_operation == OP_INS_TAIL) begin
                    n_ctl.at = w_len_cmp;
                end
                if (n_ctl.at > w_len_cmp) begin
                    n_stat = ST_BADPOS;
                end else if (w_len_cmp >= CAP_CMP) begin
                    n_stat = ST_FULL;
                end else begin
                    n_stat   = ST_DONE;
                    n_ctl.up = 1'b1;
                end
            end
            OP_DELETE: begin
                if (w_pos_cmp < w_len_cmp) begin
                    n_stat     = ST_DONE;
                    n_ctl.down = 1'b1;
                end
            end
            default: begin
                n_stat = ST_BADPOS;
            end
        endcase
    end

    // The cells act only in the execute cycle; otherwise they hold, while the
    // target position still drives their read selects.
    always_comb begin
        w_cell_ctl      = r_ctl;
        w_cell_ctl.up   = r_ctl.up && (r_state == S_EXEC);
        w_cell_ctl.down = r_ctl.down && (r_state == S_EXEC);
    end

    generate
        for (genvar k = 0; k < CAPACITY; k++) begin : g_cell
            logic [DATA_W-1:0] w_left;
            logic [DATA_W-1:0] w_right;
            if (k == 0) begin : g_first
                assign w_left = '0;
            end else begin : g_mid_l
                assign w_left = w_val[k-1];
            end
            if (k == CAPACITY - 1) begin : g_last
                assign w_right = '0;
            end else begin : g_mid_r
                assign w_right = w_val[k+1];
            end
            ili_cell u_cell (
                .i_clk   (i_clk),
                .i_ctl   (w_cell_ctl),
                .i_index (CMP_W'(k)),
                .i_left  (w_left),
                .i_right (w_right),
                .o_value (w_val[k]),
                .o_read  (w_rd[k])
            );
        end
    endgenerate

    // First level of the read tree: one OR over each group of cells. At most
    // one cell matches the position, so the OR picks out its entry.
    always_comb begin
        for (int g = 0; g < NGRP; g++) begin
            n_grp[g] = '0;
        end
        for (int k = 0; k < CAPACITY; k++) begin
            n_grp[k / GRP] = n_grp[k / GRP] | w_rd[k];
        end
    end

    always_comb begin
        w_gather = '0;
        for (int g = 0; g < NGRP; g++) begin
            w_gather = w_gather | r_grp[g];
        end
    end

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE:  if (w_accept) n_state = S_EXEC;
            S_EXEC:  n_state = S_DONE;
            S_DONE:  if (w_load_out) n_state = S_IDLE;
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_len       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (r_state == S_EXEC) begin
                if (r_ctl.up) begin
                    r_len <= r_len + LEN_W'(1);
                end else if (r_ctl.down) begin
                    r_len <= r_len - LEN_W'(1);
                end
            end
            if (w_load_out) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_ctl     <= n_ctl;
            r_stat    <= n_stat;
            r_is_read <= n_is_read;
        end
        if (r_state == S_EXEC) begin
            r_grp <= n_grp;
        end
        if (w_load_out) begin
            r_out_stat <= r_stat;
            r_out_cnt  <= COUNT_W'(CMP_W'(r_len));
            if (!r_is_read) begin
                r_out_rd <= '0;
            end else if (r_stat == ST_DONE) begin
                r_out_rd <= w_gather;
            end else begin
                r_out_rd <= '1;
            end
        end
    end

    assign o_out_valid   = r_out_valid;
    assign o_read_value  = r_out_rd;
    assign o_status      = r_out_stat;
    assign o_count_after = r_out_cnt;

endmodule

### hw/rtl/ili_checker.sv
// Port-level checks for the indexed list, attached to the top level by a bind.
module ili_checker (
    input logic                        i_clk,
    input logic                        i_rst_n,
    input logic                        o_out_valid,
    input logic                        i_out_ready,
    input logic signed [ili_pkg::DATA_W-1:0] o_read_value,
    input logic [ili_pkg::STAT_W-1:0]  o_status,
    input logic [ili_pkg::COUNT_W-1:0] o_count_after
);
    import ili_pkg::*;

    // A result never reports more entries than the list can hold.
    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> (32'(o_count_after) <= 32'(CAPACITY)))
        else $error("count_after beyond capacity");

    // A full refusal is only reported when the list is at capacity.
    a_full_len: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && (o_status == ST_FULL)) |-> (32'(o_count_after) == 32'(CAPACITY)))
        else $error("full status with list not full");

    // A refused request reports either zero or the refused-read marker.
    a_refused_value: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && (o_status != ST_DONE)) |-> ((o_read_value == '0) || (o_read_value == '1)))
        else $error("refused result with a data value");

    // A result that is not taken stays on the port unchanged.
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && !i_out_ready) |=>
            (o_out_valid && $stable(o_read_value) && $stable(o_status) && $stable(o_count_after)))
        else $error("result dropped or changed while stalled");

endmodule

bind indexed_list_insert_delete ili_checker u_ili_checker (.*);
